// File: rtl/sensor_response_word_checker_core_macros.svh
// assertion macros for the sensor response word checker
`ifndef SENSOR_RESPONSE_WORD_CHECKER_CORE_MACROS_SVH
`define SENSOR_RESPONSE_WORD_CHECKER_CORE_MACROS_SVH

// property that must hold in the same cycle as its trigger
`define SRWC_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("srwc check failed");

// property that must hold in the cycle after its trigger
`define SRWC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("srwc check failed");

`endif

// File: rtl/srwc_pkg.sv
// package: types, constants and crc function for the response word checker
package srwc_pkg;

   localparam int          DefaultMaxWords = 3;
   localparam int          CombinedWidth   = 48;
   localparam logic [7:0]  CRC_POLY        = 8'h31;
   localparam logic [7:0]  CRC_INIT        = 8'hFF;
   localparam logic [15:0] PASS_RESET      = 16'hD400;

   typedef enum logic [1:0] {
      KIND_MEASURE  = 2'd0,
      KIND_SELFTEST = 2'd1,
      KIND_SERIAL   = 2'd2,
      KIND_BASELINE = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_CRC      = 2'd1,
      STATUS_SELFTEST = 2'd2,
      STATUS_BASELINE = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      POS_HIGH = 2'd0,
      POS_LOW  = 2'd1,
      POS_CRC  = 2'd2
   } pos_type;

   typedef struct packed {
      logic [15:0]              word_value;
      logic [1:0]               word_index;
      logic                     crc_bad;
      logic                     last;
      status_type               status;
      logic [CombinedWidth-1:0] combined_value;
   } rsp_type;

   function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
      logic [7:0] c;
      c = crc ^ data;
      for (int i = 0; i < 8; i++) begin
         c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
      end
      return c;
   endfunction

endpackage

// File: rtl/srwc_framer.sv
// response framer: byte position, running crc, word count and result forming
module srwc_framer #(
   parameter int MAX_WORDS = srwc_pkg::DefaultMaxWords
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             accept,
   input  logic [7:0]       rx_byte,
   input  logic             start_req,
   input  logic [1:0]       kind,
   input  logic [15:0]      pass_pattern,
   output logic             result_valid,
   output srwc_pkg::rsp_type result
);
   import srwc_pkg::*;

   localparam logic [1:0] MaxWordsCode = 2'(MAX_WORDS);

   logic [7:0]               crc_ff, crc_in;
   pos_type                  pos_ff, pos_in;
   logic [1:0]               count_ff, count_in;
   logic [7:0]               high_ff, high_in;
   logic [7:0]               low_ff, low_in;
   kind_type                 kind_ff, kind_in;
   logic                     sticky_ff, sticky_in;
   logic [CombinedWidth-1:0] acc_ff, acc_in;

   logic [7:0]               crc_e;
   pos_type                  pos_e;
   logic [1:0]               count_e;
   kind_type                 kind_e;
   logic                     sticky_e;
   logic [CombinedWidth-1:0] acc_e;
   logic [1:0]               total;
   logic [15:0]              word;
   logic                     bad;
   logic                     is_last;
   status_type               status;

   // state as seen after a start has been applied
   always_comb begin
      if (start_req) begin
         crc_e    = CRC_INIT;
         pos_e    = POS_HIGH;
         count_e  = 2'd0;
         kind_e   = kind_type'(kind);
         sticky_e = 1'b0;
         acc_e    = '0;
      end else begin
         crc_e    = crc_ff;
         pos_e    = pos_ff;
         count_e  = count_ff;
         kind_e   = kind_ff;
         sticky_e = sticky_ff;
         acc_e    = acc_ff;
      end
   end

   always_comb begin
      unique case (kind_e)
         KIND_SELFTEST: total = 2'd1;
         KIND_SERIAL:   total = 2'd3;
         default:       total = 2'd2;
      endcase
      if (total > MaxWordsCode) begin
         total = MaxWordsCode;
      end
   end

   assign word    = {high_ff, low_ff};
   assign bad     = (crc_e != rx_byte);
   assign acc_in  = !accept ? acc_ff
                    : (count_e < total && pos_e == POS_CRC)
                    ? {acc_e[CombinedWidth-17:0], word} : acc_e;
   assign is_last = ({1'b0, count_e} + 3'd1) == {1'b0, total};

   always_comb begin
      priority if (!is_last) begin
         status = STATUS_OK;
      end else if (sticky_e || bad) begin
         status = STATUS_CRC;
      end else if (kind_e == KIND_SELFTEST && word != pass_pattern) begin
         status = STATUS_SELFTEST;
      end else if (kind_e == KIND_BASELINE && acc_in[31:0] == 32'd0) begin
         status = STATUS_BASELINE;
      end else begin
         status = STATUS_OK;
      end
   end

   always_comb begin
      crc_in       = crc_e;
      pos_in       = pos_e;
      count_in     = count_e;
      high_in      = high_ff;
      low_in       = low_ff;
      kind_in      = kind_e;
      sticky_in    = sticky_e;
      result_valid = 1'b0;
      if (!accept) begin
         crc_in    = crc_ff;
         pos_in    = pos_ff;
         count_in  = count_ff;
         kind_in   = kind_ff;
         sticky_in = sticky_ff;
      end else if (count_e < total) begin
         unique case (pos_e)
            POS_HIGH: begin
               high_in = rx_byte;
               crc_in  = crc8_byte(crc_e, rx_byte);
               pos_in  = POS_LOW;
            end
            POS_LOW: begin
               low_in = rx_byte;
               crc_in = crc8_byte(crc_e, rx_byte);
               pos_in = POS_CRC;
            end
            default: begin
               sticky_in    = sticky_e | bad;
               crc_in       = CRC_INIT;
               pos_in       = POS_HIGH;
               count_in     = count_e + 2'd1;
               result_valid = 1'b1;
            end
         endcase
      end
   end

   assign result.word_value     = word;
   assign result.word_index     = count_e;
   assign result.crc_bad        = bad;
   assign result.last           = is_last;
   assign result.status         = status;
   assign result.combined_value = acc_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff    <= CRC_INIT;
         pos_ff    <= POS_HIGH;
         count_ff  <= 2'd0;
         kind_ff   <= KIND_MEASURE;
         sticky_ff <= 1'b0;
         acc_ff    <= '0;
      end else begin
         crc_ff    <= crc_in;
         pos_ff    <= pos_in;
         count_ff  <= count_in;
         kind_ff   <= kind_in;
         sticky_ff <= sticky_in;
         acc_ff    <= acc_in;
      end
   end

   always_ff @(posedge clock) begin
      high_ff <= high_in;
      low_ff  <= low_in;
   end

endmodule

// File: rtl/srwc_out_reg.sv
// result register with valid/ready towards the consumer
module srwc_out_reg (
   input  logic              clock,
   input  logic              reset,
   input  logic              load,
   input  srwc_pkg::rsp_type load_data,
   input  logic              rsp_ready,
   output logic              rsp_valid,
   output logic              can_accept,
   output srwc_pkg::rsp_type rsp_data
);
   import srwc_pkg::*;

   logic    valid_ff, valid_in;
   rsp_type data_ff, data_in;

   assign can_accept = !valid_ff || rsp_ready;

   always_comb begin
      valid_in = valid_ff && !rsp_ready;
      data_in  = data_ff;
      if (load) begin
         valid_in = 1'b1;
         data_in  = load_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

// File: rtl/sensor_response_word_checker_core.sv
// top level: crc-8 checked response word framer with self-test pattern register
// output: a result is registered and appears in the cycle after the crc byte of a word is accepted
// throughput: one byte per cycle; input ready drops in any cycle in which a
// held result is not taken
// reset: synchronous, clears framer control state (not the data bytes), output valid and sets the pass pattern
module sensor_response_word_checker_core #(
   parameter int MAX_WORDS = srwc_pkg::DefaultMaxWords
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [7:0]                          req_rx_byte,
   input  logic                                req_start_req,
   input  logic [1:0]                          req_kind,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [15:0]                         rsp_word_value,
   output logic [1:0]                          rsp_word_index,
   output logic                                rsp_crc_bad,
   output logic                                rsp_last,
   output logic [1:0]                          rsp_status,
   output logic [srwc_pkg::CombinedWidth-1:0]  rsp_combined_value,
   input  logic                                csr_wr_en,
   input  logic [15:0]                         csr_wr_data
);
   import srwc_pkg::*;

   `include "sensor_response_word_checker_core_macros.svh"

   logic [15:0] pass_pattern_ff, pass_pattern_in;
   logic        accept;
   logic        result_valid;
   rsp_type     result;
   rsp_type     rsp_data;

   assign pass_pattern_in = csr_wr_en ? csr_wr_data : pass_pattern_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pass_pattern_ff <= PASS_RESET;
      end else begin
         pass_pattern_ff <= pass_pattern_in;
      end
   end

   assign accept = req_valid && req_ready;

   srwc_framer #(
      .MAX_WORDS(MAX_WORDS)
   ) u_framer (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .rx_byte      (req_rx_byte),
      .start_req    (req_start_req),
      .kind         (req_kind),
      .pass_pattern (pass_pattern_ff),
      .result_valid (result_valid),
      .result       (result)
   );

   srwc_out_reg u_out_reg (
      .clock      (clock),
      .reset      (reset),
      .load       (result_valid),
      .load_data  (result),
      .rsp_ready  (rsp_ready),
      .rsp_valid  (rsp_valid),
      .can_accept (req_ready),
      .rsp_data   (rsp_data)
   );

   assign rsp_word_value     = rsp_data.word_value;
   assign rsp_word_index     = rsp_data.word_index;
   assign rsp_crc_bad        = rsp_data.crc_bad;
   assign rsp_last           = rsp_data.last;
   assign rsp_status         = rsp_data.status;
   assign rsp_combined_value = rsp_data.combined_value;

   `SRWC_ASSERT_SAME(a_stall_blocks_input, clock, reset, rsp_valid && !rsp_ready, !req_ready)
   `SRWC_ASSERT_SAME(a_status_only_last, clock, reset, rsp_valid && rsp_status != STATUS_OK, rsp_last)
   `SRWC_ASSERT_SAME(a_bad_last_is_crc, clock, reset, rsp_valid && rsp_last && rsp_crc_bad, rsp_status == STATUS_CRC)
   `SRWC_ASSERT_SAME(a_word_in_combined, clock, reset, rsp_valid, rsp_combined_value[15:0] == rsp_word_value)

endmodule
